>>> rtl/ffc_pkg.sv
// Shared constants, rounding-mode codes and stage payload types for the
// fixed-point to packed-float converter. No dependencies.
package ffc_pkg;

    // Word geometry.
    localparam int FIX_W      = 32;
    localparam int FLOAT_W    = 17;
    localparam int MAN_W      = 8;
    localparam int EXPW       = FLOAT_W - MAN_W - 1;
    localparam int LEADW      = (FIX_W > 1) ? $clog2(FIX_W) : 1;
    localparam int ALIGN_W    = FIX_W + MAN_W;

    // Port widths (fields padded to whole bytes).
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = ((FLOAT_W + 7) / 8) * 8;

    // Rounding-mode register codes.
    typedef enum logic [2:0] {
        RND_TRUNC      = 3'd0,
        RND_TRUNC_ZERO = 3'd1,
        RND_PLUS_INF   = 3'd2,
        RND_MINUS_INF  = 3'd3,
        RND_INF        = 3'd4,
        RND_ZERO       = 3'd5,
        RND_EVEN       = 3'd6,
        RND_ODD        = 3'd7
    } rnd_mode_t;

    // Stage 1 result: sign and magnitude.
    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [FIX_W-1:0] mag;
    } st1_t;

    // Stage 2 result: magnitude with its leading-one index.
    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [FIX_W-1:0] mag;
        logic [EXPW-1:0]  expo;
    } st2_t;

    // Stage 3 result: aligned mantissa and rounding bits.
    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [EXPW-1:0]  expo;
        logic [MAN_W-1:0] man;
        logic             ulp;
        logic             guard;
        logic             sticky;
    } st3_t;

endpackage

>>> rtl/ffc_negate.sv
// Pipeline stage 1: takes the two's complement word apart into sign and
// magnitude and flags a zero word. Depends on ffc_pkg.
module ffc_negate (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ffc_pkg::FIX_W-1:0]  in_raw,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ffc_pkg::st1_t              out_data
);

    logic          valid_reg;
    logic          valid_next;
    ffc_pkg::st1_t data_reg;
    ffc_pkg::st1_t data_next;
    logic          load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        data_next.sign = in_raw[ffc_pkg::FIX_W-1];
        data_next.zero = (in_raw == '0);
        // The most negative word wraps to its own pattern, read as unsigned.
        data_next.mag  = in_raw[ffc_pkg::FIX_W-1] ? (~in_raw + 1'b1) : in_raw;
        valid_next     = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/ffc_lzd.sv
// Pipeline stage 2: leading-one detection over the magnitude, giving the
// unbiased exponent. Depends on ffc_pkg.
module ffc_lzd (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ffc_pkg::st1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ffc_pkg::st2_t out_data
);

    logic                       valid_reg;
    logic                       valid_next;
    ffc_pkg::st2_t              data_reg;
    ffc_pkg::st2_t              data_next;
    logic [ffc_pkg::LEADW-1:0]  lead;
    logic                       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Priority encoder: the highest set bit wins.
    always_comb begin
        lead = '0;
        for (int i = 0; i < ffc_pkg::FIX_W; i++) begin
            if (in_data.mag[i]) begin
                lead = ffc_pkg::LEADW'(i);
            end
        end
    end

    always_comb begin
        data_next.sign = in_data.sign;
        data_next.zero = in_data.zero;
        data_next.mag  = in_data.mag;
        data_next.expo = ffc_pkg::EXPW'(lead);
        valid_next     = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/ffc_align.sv
// Pipeline stage 3: barrel shift of the magnitude into the mantissa field,
// with ulp, guard and sticky bits for large exponents. Depends on ffc_pkg.
module ffc_align (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ffc_pkg::st2_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ffc_pkg::st3_t out_data
);

    logic                         valid_reg;
    logic                         valid_next;
    ffc_pkg::st3_t                data_reg;
    ffc_pkg::st3_t                data_next;
    logic                         load;
    logic [ffc_pkg::ALIGN_W-1:0]  mw;
    logic [ffc_pkg::ALIGN_W-1:0]  rshifted;
    logic [ffc_pkg::ALIGN_W-1:0]  lshifted;
    logic [ffc_pkg::ALIGN_W-1:0]  gmask;
    logic [ffc_pkg::EXPW-1:0]     rsh;
    logic [ffc_pkg::EXPW-1:0]     lsh;
    logic                         big;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        mw       = ffc_pkg::ALIGN_W'(in_data.mag);
        big      = (in_data.expo >= ffc_pkg::EXPW'(ffc_pkg::MAN_W));
        rsh      = in_data.expo - ffc_pkg::EXPW'(ffc_pkg::MAN_W);
        lsh      = ffc_pkg::EXPW'(ffc_pkg::MAN_W) - in_data.expo;
        rshifted = mw >> rsh;
        lshifted = mw << lsh;
        gmask    = (rsh != '0) ? (ffc_pkg::ALIGN_W'(1) << (rsh - 1'b1)) : '0;

        data_next.sign = in_data.sign;
        data_next.zero = in_data.zero;
        data_next.expo = in_data.expo;
        if (big) begin
            data_next.man    = rshifted[ffc_pkg::MAN_W-1:0];
            data_next.ulp    = rshifted[0];
            data_next.guard  = |(mw & gmask);
            data_next.sticky = (rsh != '0) && (|(mw & (gmask - ffc_pkg::ALIGN_W'(1))));
        end else begin
            // Exact left alignment; nothing is dropped, so no rounding.
            data_next.man    = lshifted[ffc_pkg::MAN_W-1:0];
            data_next.ulp    = 1'b0;
            data_next.guard  = 1'b0;
            data_next.sticky = 1'b0;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/ffc_round.sv
// Pipeline stage 4: rounding increment, exponent carry and packing into the
// output register. Depends on ffc_pkg.
module ffc_round (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ffc_pkg::rnd_mode_t           rnd_mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ffc_pkg::st3_t                in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffc_pkg::FLOAT_W-1:0]  out_word
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [ffc_pkg::FLOAT_W-1:0]  word_reg;
    logic [ffc_pkg::FLOAT_W-1:0]  word_next;
    logic                         load;
    logic                         inc;
    logic [ffc_pkg::MAN_W:0]      man_sum;
    logic [ffc_pkg::EXPW-1:0]     expo_rnd;

    function automatic logic round_inc(ffc_pkg::rnd_mode_t mode, logic s, logic u,
                                       logic g, logic r);
        logic res;
        case (mode)
            ffc_pkg::RND_TRUNC:      res = 1'b0;
            ffc_pkg::RND_TRUNC_ZERO: res = s & (g | r);
            ffc_pkg::RND_PLUS_INF:   res = g;
            ffc_pkg::RND_MINUS_INF:  res = g & r;
            ffc_pkg::RND_INF:        res = g & (!s | r);
            ffc_pkg::RND_ZERO:       res = g & (s | r);
            ffc_pkg::RND_EVEN:       res = g & (u | r);
            ffc_pkg::RND_ODD:        res = g & (!u | r);
            default:                 res = 1'b0;
        endcase
        return res;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        inc      = round_inc(rnd_mode, in_data.sign, in_data.ulp, in_data.guard,
                             in_data.sticky);
        man_sum  = {1'b0, in_data.man} + {{ffc_pkg::MAN_W{1'b0}}, inc};
        // A mantissa carry leaves the field clear and bumps the exponent.
        expo_rnd = in_data.expo + {{(ffc_pkg::EXPW-1){1'b0}}, man_sum[ffc_pkg::MAN_W]};
        if (in_data.zero) begin
            word_next = ffc_pkg::FLOAT_W'(1) << (ffc_pkg::FLOAT_W - 2);
        end else begin
            word_next = {in_data.sign, expo_rnd, man_sum[ffc_pkg::MAN_W-1:0]};
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/fixed_to_float_converter_unit.sv
// Fixed-point to packed-float converter, top level. Depends on ffc_pkg and the
// four stage modules ffc_negate, ffc_lzd, ffc_align and ffc_round.
// Throughput: one beat per cycle while m_tready is high, set by the four-stage register pipeline.
// Reset: aresetn (synchronous, active low) empties every stage and sets the
// rounding mode to round-to-nearest-even.
module fixed_to_float_converter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: rounding mode, written whenever cfg_wr_en is high.
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_wr_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffc_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] fixed_value (signed)
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffc_pkg::M_TDATA_W-1:0]     m_tdata    // [16:0] float_word, rest zero
);

    // The rounding mode must be changed only while the pipeline is empty (the block
    // does not enforce this); then a single register read by the last stage suffices.
    ffc_pkg::rnd_mode_t rnd_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_mode_reg <= ffc_pkg::RND_EVEN;
        end else if (cfg_wr_en) begin
            rnd_mode_reg <= ffc_pkg::rnd_mode_t'(cfg_wr_data);
        end
    end

    // Each stage holds one beat and has its own valid bit; a stage takes a new
    // beat whenever it is empty or its successor is taking its beat, so bubbles
    // close up while the output is stalled.
    logic                         v1, v2, v3;
    logic                         r2, r3, r4;
    ffc_pkg::st1_t                st1;
    ffc_pkg::st2_t                st2;
    ffc_pkg::st3_t                st3;
    logic [ffc_pkg::FLOAT_W-1:0]  float_word;

    ffc_negate u_negate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_raw    (s_tdata[ffc_pkg::FIX_W-1:0]),
        .out_valid (v1),
        .out_ready (r2),
        .out_data  (st1)
    );

    ffc_lzd u_lzd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_data   (st1),
        .out_valid (v2),
        .out_ready (r3),
        .out_data  (st2)
    );

    ffc_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_data   (st2),
        .out_valid (v3),
        .out_ready (r4),
        .out_data  (st3)
    );

    ffc_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rnd_mode  (rnd_mode_reg),
        .in_valid  (v3),
        .in_ready  (r4),
        .in_data   (st3),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (float_word)
    );

    // The result word sits in the low bits; the padding up to a byte is zero.
    assign m_tdata = ffc_pkg::M_TDATA_W'(float_word);

    // A beat held in stage 3 by a stalled final stage must not change.
    a_st3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !r4) |=> (v3 && $stable(st3)))
        else $error("stage 3 beat changed while stalled");

    // The exponent from the leading-one detector must point at the top set bit.
    a_lead_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2 && !st2.zero) |-> ((st2.mag >> st2.expo) == ffc_pkg::FIX_W'(1)))
        else $error("leading-one index does not match the magnitude");

    // Small exponents are aligned exactly and must carry no rounding bits.
    a_small_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && (st3.expo < ffc_pkg::EXPW'(ffc_pkg::MAN_W))) |-> (!st3.guard && !st3.sticky))
        else $error("rounding bits set for an exactly aligned mantissa");

endmodule

>>> tb/fixed_to_float_converter_unit_tb.sv
// Self-checking testbench for fixed_to_float_converter_unit: streams fixed-point beats through
// the converter under every rounding mode and checks each packed float against its own predictor.
// Depends on ffc_pkg and the converter RTL only.
`timescale 1ns / 100ps

module fixed_to_float_converter_unit_tb;

    localparam int PAD_W      = ffc_pkg::M_TDATA_W - ffc_pkg::FLOAT_W;

    // One conversion awaiting its result: the input word is kept for the report.
    typedef struct packed {
        logic [ffc_pkg::FIX_W-1:0]   fixed;
        logic [ffc_pkg::FLOAT_W-1:0] word;
    } conversion_t;

    // Directed values: the extremes of the input, the zero word, exact small magnitudes,
    // the first exponent that rounds, ties, guard-only and sticky-only tails, and a
    // mantissa of all ones that carries into the exponent, in both signs.
    localparam logic [ffc_pkg::FIX_W-1:0] DIRECTED [24] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h0000_0003, 32'h0000_00FF,
        32'h0000_0100, 32'h0000_0101, 32'h0000_0201, 32'h0000_0203,
        32'h0000_03FF, 32'h0000_0402, 32'h0000_0403, 32'h0000_0401,
        32'hFFFF_FDFF, 32'hFFFF_FC01, 32'hFFFF_FBFD, 32'hFFFF_FF00,
        32'h0180_0000, 32'h7F80_0000, 32'hFE7F_FFFF, 32'h5555_5555
    };

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [2:0]                     cfg_wr_data = ffc_pkg::RND_EVEN;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [ffc_pkg::S_TDATA_W-1:0]  s_tdata     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [ffc_pkg::M_TDATA_W-1:0]  m_tdata;

    // The converter's rounding mode as this bench believes it to be.
    ffc_pkg::rnd_mode_t             rounding_mode = ffc_pkg::RND_EVEN;

    logic [ffc_pkg::FIX_W-1:0]      pending_fixed[$];
    conversion_t                    expected_floats[$];
    conversion_t                    oldest;
    logic                           s_beat_taken = 1'b0;
    int                             send_idle_pct = 0;
    int                             stall_pct     = 0;
    int                             fail_count    = 0;

    fixed_to_float_converter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // [31:0] fixed_value (signed)
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)    // [16:0] float_word, rest zero
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Converts one fixed-point word into the packed float the block should return under
    // the given rounding mode: sign on top, leading-one index as exponent, hidden-one mantissa.
    function automatic logic [ffc_pkg::FLOAT_W-1:0] float_of_fixed(
            input logic [ffc_pkg::FIX_W-1:0] fx, input ffc_pkg::rnd_mode_t mode);
        logic                        sgn;
        logic                        ulp;
        logic                        guard;
        logic                        sticky;
        logic                        inc;
        logic [ffc_pkg::FIX_W-1:0]   mag;
        logic [ffc_pkg::FIX_W-1:0]   bits;
        logic [ffc_pkg::EXPW-1:0]    ex;
        logic [ffc_pkg::MAN_W:0]     man_sum;
        logic [ffc_pkg::FLOAT_W-1:0] zero_word;
        int                          lead;
        int                          sh;
        // Zero has no leading one; it has a fixed encoding of its own.
        if (fx == '0) begin
            zero_word = ffc_pkg::FLOAT_W'(1);
            return zero_word << (ffc_pkg::FLOAT_W - 2);
        end
        sgn = fx[ffc_pkg::FIX_W-1];
        // The magnitude wraps, so the most negative word gives 2^(FIX_W-1).
        mag = sgn ? -fx : fx;
        lead = 0;
        for (int i = 0; i < ffc_pkg::FIX_W; i++) begin
            if (mag[i]) begin
                lead = i;
            end
        end
        ex = ffc_pkg::EXPW'(lead);
        if (ex >= ffc_pkg::MAN_W) begin
            sh = ex - ffc_pkg::MAN_W;
            ulp = mag[sh];
            guard = 1'b0;
            sticky = 1'b0;
            if (sh >= 1) begin
                guard = mag[sh-1];
            end
            if (sh >= 2) begin
                bits = mag & ((ffc_pkg::FIX_W'(1) << (sh - 1)) - 1);
                sticky = |bits;
            end
            case (mode)
                ffc_pkg::RND_TRUNC:      inc = 1'b0;
                ffc_pkg::RND_TRUNC_ZERO: inc = sgn & (guard | sticky);
                ffc_pkg::RND_PLUS_INF:   inc = guard;
                ffc_pkg::RND_MINUS_INF:  inc = guard & sticky;
                ffc_pkg::RND_INF:        inc = guard & (~sgn | sticky);
                ffc_pkg::RND_ZERO:       inc = guard & (sgn | sticky);
                ffc_pkg::RND_EVEN:       inc = guard & (ulp | sticky);
                default:                 inc = guard & (~ulp | sticky);
            endcase
            bits = mag >> sh;
            man_sum = {1'b0, bits[ffc_pkg::MAN_W-1:0]} + inc;
            // A carry out of the mantissa bumps the exponent and leaves the mantissa clear.
            ex = ex + man_sum[ffc_pkg::MAN_W];
            return {sgn, ex, man_sum[ffc_pkg::MAN_W-1:0]};
        end
        // Small magnitudes fit exactly: the bits under the leading one are left-aligned.
        bits = mag << (ffc_pkg::MAN_W - ex);
        return {sgn, ex, bits[ffc_pkg::MAN_W-1:0]};
    endfunction

    // Random fixed-point word. Most are built from a chosen leading-one position so that
    // every exponent turns up, and half of the rounding cases get a shaped tail: an exact
    // tie, a sticky-only tail, guard and sticky together, or a run of ones that carries.
    function automatic logic [ffc_pkg::FIX_W-1:0] random_fixed();
        int                        kind;
        int                        lead;
        int                        sh;
        logic [ffc_pkg::FIX_W-1:0] mag;
        logic [ffc_pkg::FIX_W-1:0] tail;
        kind = $urandom_range(9);
        if (kind == 0) begin
            return $urandom;
        end
        if (kind == 1) begin
            mag = $urandom_range(300);
            return $urandom_range(1) ? -mag : mag;
        end
        lead = $urandom_range(ffc_pkg::FIX_W - 1);
        mag = (ffc_pkg::FIX_W'(1) << lead) | ($urandom & ((ffc_pkg::FIX_W'(1) << lead) - 1));
        if (lead > ffc_pkg::MAN_W && $urandom_range(1)) begin
            sh = lead - ffc_pkg::MAN_W;
            tail = (ffc_pkg::FIX_W'(1) << sh) - 1;
            mag = mag & ~tail;
            case ($urandom_range(3))
                0:       mag = mag | (ffc_pkg::FIX_W'(1) << (sh - 1));
                1:       mag = mag | ((ffc_pkg::FIX_W'(1) << (sh - 1)) - 1);
                2:       mag = mag | tail;
                default: mag = mag | ((ffc_pkg::FIX_W'(1) << lead) - 1);
            endcase
        end
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Waits until every queued beat has gone in and every expected result has come out,
    // then idles with the input empty so that the four-stage pipeline can show any stray beat.
    task automatic wait_until_drained();
        do begin
            @(negedge aclk);
        end while (pending_fixed.size() != 0 || s_tvalid || expected_floats.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    // Driver: presents a new input beat once the previous one has been taken, or idles at
    // random, and throttles the result side. Everything changes on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_taken) begin
            if (pending_fixed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_fixed.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: every accepted input beat yields one expected float, and every accepted
    // result beat is checked against the oldest one still waiting.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_floats.push_back('{s_tdata, float_of_fixed(s_tdata, rounding_mode)});
            end
            if (m_tvalid && m_tready) begin
                if (expected_floats.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with no conversion outstanding: expected none, got %h",
                             $time, m_tdata);
                end else begin
                    oldest = expected_floats.pop_front();
                    // The float word and the zero fill above it are checked together.
                    if (m_tdata !== {{PAD_W{1'b0}}, oldest.word}) begin
                        fail_count++;
                        $display("%0t: float_word for fixed %h: expected %h, got %h",
                                 $time, oldest.fixed, oldest.word, m_tdata);
                    end
                end
            end
        end
        s_beat_taken <= aresetn && s_tvalid && s_tready;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats under the reset rounding mode, with no idling on either side.
        foreach (DIRECTED[i]) begin
            pending_fixed.push_back(DIRECTED[i]);
        end
        wait_until_drained();

        // Random phases: every rounding mode in turn, then a few chosen at random, with
        // the idling pattern rotating through no gaps, gaps on the input, stalls on the output and both.
        for (int phase = 0; phase < 12; phase++) begin
            rounding_mode = (phase < 8) ? ffc_pkg::rnd_mode_t'(phase)
                                        : ffc_pkg::rnd_mode_t'($urandom_range(7));
            cfg_wr_data <= rounding_mode;
            cfg_wr_en   <= 1'b1;
            @(negedge aclk);
            cfg_wr_en   <= 1'b0;
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default: begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            repeat (150) begin
                pending_fixed.push_back(random_fixed());
            end
            wait_until_drained();
        end

        if (fail_count == 0 && expected_floats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of some 2000 beats.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
